@@ sv/cdq_pkg.sv @@
// cdq_pkg: shared types and constants for the circular deque
// opcode codes, field widths, controller/datapath command and status structs
// no dependencies
package cdq_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 2;
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned CAP_DEF     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4
  } cdq_op_e;

  // controller to datapath
  typedef struct packed {
    logic step;     // request accepted, commit state
    logic load_rd;  // move the read word into the result
  } cdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_rd;  // current request leaves a new end value in memory
  } cdq_stat_t;

endpackage

@@ sv/cdq_ctrl.sv @@
// cdq_ctrl: request sequencer and result valid for the circular deque
// depends on cdq_pkg
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  cdq_stat_t stat_i,
  output cdq_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } cdq_state_e;

  cdq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.step    = 1'b0;
    cmd_o.load_rd = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.step = 1'b1;
          if (stat_i.need_rd) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_o.load_rd = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((cmd_o.step && !stat_i.need_rd) || cmd_o.load_rd) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/cdq_datapath.sv @@
// cdq_datapath: ring memory, end indices, count, capacity and result registers
// depends on cdq_pkg; driven by cdq_ctrl commands
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cdq_cmd_t                 cmd_i,
  output cdq_stat_t                stat_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output logic [CFG_W-1:0]         cfg_rdata_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     error_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] rear_value_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [COUNT_W-1:0]       count_o
);

  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned CAP_RST = (CAP_DEF > DEPTH) ? DEPTH : CAP_DEF;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [IW-1:0] front_q, front_d, rear_q, rear_d;
  logic [CW-1:0] count_q, count_d, cap_q;
  logic [CW-1:0] front_up, rear_up;
  logic [DATA_W-1:0] fval_q, fval_d, rval_q, rval_d;
  logic [DATA_W-1:0] rd_q;
  logic          rd_front_q;

  logic          err;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic          need_rd, rd_front;
  logic          cur_empty, cur_full;

  assign cur_empty = (count_q == '0);
  assign cur_full  = (count_q == cap_q);
  assign front_up  = CW'(front_q) + CW'(1);
  assign rear_up   = CW'(rear_q) + CW'(1);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    count_d  = count_q;
    fval_d   = fval_q;
    rval_d   = rval_q;
    err      = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    rd_addr  = '0;
    need_rd  = 1'b0;
    rd_front = 1'b0;
    case (opcode_i)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (cur_full) begin
          err = 1'b1;
        end else if (cur_empty) begin
          front_d = '0;
          rear_d  = '0;
          count_d = CW'(1);
          wr_en   = 1'b1;
          wr_addr = '0;
          fval_d  = value_i;
          rval_d  = value_i;
        end else if (opcode_i == OP_PUSH_FRONT) begin
          front_d = (front_q == '0) ? IW'(cap_q - CW'(1)) : front_q - IW'(1);
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = front_d;
          fval_d  = value_i;
        end else begin
          rear_d  = (rear_up >= cap_q) ? '0 : IW'(rear_up);
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = rear_d;
          rval_d  = value_i;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (cur_empty) begin
          err = 1'b1;
        end else if (count_q == CW'(1)) begin
          count_d = '0;
        end else if (opcode_i == OP_POP_FRONT) begin
          front_d  = (front_up >= cap_q) ? '0 : IW'(front_up);
          count_d  = count_q - CW'(1);
          rd_addr  = front_d;
          need_rd  = 1'b1;
          rd_front = 1'b1;
        end else begin
          rear_d  = (rear_q == '0) ? IW'(cap_q - CW'(1)) : rear_q - IW'(1);
          count_d = count_q - CW'(1);
          rd_addr = rear_d;
          need_rd = 1'b1;
        end
      end
      default: begin
        // no operation, unused codes included
      end
    endcase
  end

  assign stat_o.need_rd = need_rd;

  // ring memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && wr_en) begin
      mem[wr_addr] <= value_i;
    end
    if (cmd_i.step && need_rd) begin
      rd_q       <= mem[rd_addr];
      rd_front_q <= rd_front;
    end
  end

  // indices, count, capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      cap_q   <= CW'(CAP_RST);
    end else if (cfg_we_i) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      if (cfg_wdata_i == '0) begin
        cap_q <= CW'(1);
      end else if (32'(cfg_wdata_i) > 32'(DEPTH)) begin
        cap_q <= CW'(DEPTH);
      end else begin
        cap_q <= CW'(cfg_wdata_i);
      end
    end else if (cmd_i.step) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
    end
  end

  // cached end values and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      fval_q <= fval_d;
      rval_q <= rval_d;
      if (!need_rd) begin
        error_o       <= err;
        front_value_o <= (count_d == '0) ? '1 : fval_d;
        rear_value_o  <= (count_d == '0) ? '1 : rval_d;
        is_empty_o    <= (count_d == '0);
        is_full_o     <= (count_d == cap_q);
        count_o       <= COUNT_W'(count_d);
      end
    end else if (cmd_i.load_rd) begin
      if (rd_front_q) begin
        fval_q <= rd_q;
      end else begin
        rval_q <= rd_q;
      end
      error_o       <= 1'b0;
      front_value_o <= rd_front_q ? rd_q : fval_q;
      rear_value_o  <= rd_front_q ? rval_q : rd_q;
      is_empty_o    <= 1'b0;
      is_full_o     <= (count_q == cap_q);
      count_o       <= COUNT_W'(count_q);
    end
  end

  assign cfg_rdata_o = CFG_W'(cap_q);

endmodule

@@ sv/circular_deque.sv @@
// circular_deque: double-ended queue held in a ring memory of DEPTH words
// results are registered; pushes, no-ops, errors and the pop of the last
//   element update them from the request, while a pop that exposes a new end
//   first passes the registered read of the ring memory and a read state
// throughput: one request per cycle unless stalled or in a pop's read state
// reset: deque empty, both indices zero, capacity min(16, DEPTH); no clearing
//   pass, memory entries are only read after they were written
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     error_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] rear_value_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [COUNT_W-1:0]       count_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  cdq_cmd_t        cmd;
  cdq_stat_t       stat;
  logic            cfg_we;
  logic [CFG_W-1:0] cfg_rdata;

  // single register, capacity, written at any address, read back at address zero
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr == '0) ? APB_DATA_W'(cfg_rdata) : '0;

  // sequencer: accepts a request when idle and the result register is free,
  // and waits in a read state when a pop needs the new end from memory
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // ring memory, indices, count and the result payload registers
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[CFG_W-1:0]),
    .cfg_rdata_o   (cfg_rdata),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .error_o       (error_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .count_o       (count_o)
  );

endmodule
